>>> hw/rtl/gq_pkg.sv
package gq_pkg;

  // Field widths
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned LUMA_W  = 18;
  localparam int unsigned DIVD_W  = 19;
  localparam int unsigned QUO_W   = 11;
  localparam int unsigned REM_W   = 8;
  localparam int unsigned HUE_W   = 13;
  localparam int unsigned XDIF_W  = 9;
  localparam int unsigned GIDX_W  = 4;
  localparam int unsigned GLYPH_W = 2;
  localparam int unsigned COL_W   = 4;
  localparam int unsigned MODE_W  = 2;

  // Divider pipeline: quotient bits resolved per stage
  localparam int unsigned DIV_STEPS  = 3;
  localparam int unsigned DIV_STAGES = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;

  // Render modes (zero behaves as hue mode)
  localparam logic [MODE_W-1:0] MODE_BW    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GREY  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_HUE   = 2'd3;
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_HUE;

  // Palette and glyph codes
  localparam logic [COL_W-1:0]   COL_BLACK  = 4'd0;
  localparam logic [COL_W-1:0]   COL_DGREY  = 4'd8;
  localparam logic [COL_W-1:0]   COL_GREY   = 4'd7;
  localparam logic [COL_W-1:0]   COL_WHITE  = 4'd15;
  localparam logic [GLYPH_W-1:0] GLYPH_SOLID = 2'd3;

  // Hue band edges in sixteenths of a degree
  localparam logic [HUE_W-1:0] HUE_60  = 13'd960;
  localparam logic [HUE_W-1:0] HUE_160 = 13'd2560;
  localparam logic [HUE_W-1:0] HUE_180 = 13'd2880;
  localparam logic [HUE_W-1:0] HUE_240 = 13'd3840;
  localparam logic [HUE_W-1:0] HUE_300 = 13'd4800;

  // One glyph step is 15 degrees
  localparam int unsigned GLYPH_STEP = 240;
  localparam int unsigned GLYPH_CMPS = 8;

  // Luma thresholds: ramp index k is reached when 13*L >= 255000*k
  localparam int unsigned RAMP_TOP = 12;
  localparam logic [LUMA_W-1:0] LUMA_THR [RAMP_TOP] = '{
    18'd19616,  18'd39231,  18'd58847,  18'd78462,
    18'd98077,  18'd117693, 18'd137308, 18'd156924,
    18'd176539, 18'd196154, 18'd215770, 18'd235385
  };

  // Which channel holds the max, and the hue direction in the red sector
  typedef enum logic [1:0] {
    SEC_RED_UP,
    SEC_GREEN,
    SEC_BLUE,
    SEC_RED_DOWN
  } sector_t;

  // Per-pixel control that rides along the arithmetic
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              use_grey;
    logic              dark;
    sector_t           sector;
    logic [GIDX_W-1:0] gidx;
    logic              g_msb;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [DIVD_W-1:0] dividend;
    logic [PIX_W-1:0]  divisor;
  } div_in_t;

  typedef struct packed {
    side_t            side;
    logic [QUO_W-1:0] quot;
  } div_out_t;

  typedef struct packed {
    logic [COL_W-1:0]   back;
    logic [COL_W-1:0]   fore;
    logic [GLYPH_W-1:0] glyph;
  } result_t;

  function automatic logic [HUE_W-1:0] sector_base(sector_t s);
    logic [HUE_W-1:0] b;
    case (s)
      SEC_RED_UP:   b = '0;
      SEC_GREEN:    b = HUE_60;
      SEC_BLUE:     b = HUE_180;
      SEC_RED_DOWN: b = HUE_300;
      default:      b = '0;
    endcase
    return b;
  endfunction

  function automatic logic [2:0] hue_band(logic [HUE_W-1:0] h);
    logic [2:0] band;
    if (h < HUE_60)       band = 3'd0;
    else if (h < HUE_160) band = 3'd1;
    else if (h < HUE_180) band = 3'd2;
    else if (h < HUE_240) band = 3'd3;
    else if (h < HUE_300) band = 3'd4;
    else                  band = 3'd5;
    return band;
  endfunction

  // floor(q / 240) mod 4; sector bases are multiples of 960
  function automatic logic [GLYPH_W-1:0] quot_glyph(logic [QUO_W-1:0] q);
    logic [3:0] cnt;
    cnt = '0;
    for (int k = 1; k <= GLYPH_CMPS; k++) begin
      if (q >= QUO_W'(GLYPH_STEP * k)) begin
        cnt = cnt + 4'd1;
      end
    end
    return cnt[GLYPH_W-1:0];
  endfunction

  function automatic logic [COL_W-1:0] band_fore(logic [2:0] band, logic dark);
    logic [COL_W-1:0] c;
    case (band)
      3'd0:    c = 4'd6;
      3'd1:    c = 4'd2;
      3'd2:    c = 4'd3;
      3'd3:    c = 4'd1;
      3'd4:    c = 4'd5;
      default: c = 4'd4;
    endcase
    // light colors sit eight above the dark ones
    return dark ? c : (c | 4'd8);
  endfunction

  function automatic logic [COL_W-1:0] band_back(logic [2:0] band, logic dark);
    logic [COL_W-1:0] c;
    case (band)
      3'd0:    c = 4'd4;
      3'd1:    c = 4'd6;
      3'd2:    c = 4'd2;
      3'd3:    c = 4'd3;
      3'd4:    c = 4'd1;
      default: c = 4'd5;
    endcase
    return dark ? c : (c | 4'd8);
  endfunction

endpackage

>>> hw/rtl/gq_front.sv
module gq_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [gq_pkg::PIX_W-1:0]   in_red,
  input  logic [gq_pkg::PIX_W-1:0]   in_green,
  input  logic [gq_pkg::PIX_W-1:0]   in_blue,
  input  logic [gq_pkg::MODE_W-1:0]  mode,
  output logic                       out_valid,
  input  logic                       out_ready,
  output gq_pkg::div_in_t            out_data
);

  // Stage 1 registers
  logic                        s1_valid_r;
  logic [gq_pkg::MODE_W-1:0]   s1_mode_r,  s1_mode_nxt;
  logic [gq_pkg::PIX_W-1:0]    s1_mx_r,    s1_mx_nxt;
  logic [gq_pkg::PIX_W-1:0]    s1_d_r,     s1_d_nxt;
  gq_pkg::sector_t             s1_sec_r,   s1_sec_nxt;
  logic [gq_pkg::XDIF_W-1:0]   s1_x_r,     s1_x_nxt;
  logic [gq_pkg::LUMA_W-1:0]   s1_luma_r,  s1_luma_nxt;
  logic                        s1_gmsb_r,  s1_gmsb_nxt;

  // Stage 2 registers
  logic                        s2_valid_r;
  gq_pkg::div_in_t             s2_data_r,  s2_data_nxt;

  logic                        s1_ready, s2_ready;
  logic [gq_pkg::PIX_W-1:0]    mn;
  logic [gq_pkg::XDIF_W:0]     xsum;
  logic [10:0]                 d5;
  logic [gq_pkg::GIDX_W-1:0]   gcnt;

  // Each stage moves when it is empty or its word moves on
  assign s2_ready = !s2_valid_r || out_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  // Stage 1: max, min, spread, sector, hue numerator term and luma
  always_comb begin
    s1_mx_nxt = in_red;
    mn        = in_red;
    if (in_green > s1_mx_nxt) s1_mx_nxt = in_green;
    if (in_blue > s1_mx_nxt)  s1_mx_nxt = in_blue;
    if (in_green < mn)        mn = in_green;
    if (in_blue < mn)         mn = in_blue;
    s1_d_nxt = s1_mx_nxt - mn;

    if (s1_mx_nxt == in_red) begin
      s1_sec_nxt = (in_green >= in_blue) ? gq_pkg::SEC_RED_UP : gq_pkg::SEC_RED_DOWN;
    end else if (s1_mx_nxt == in_green) begin
      s1_sec_nxt = gq_pkg::SEC_GREEN;
    end else begin
      s1_sec_nxt = gq_pkg::SEC_BLUE;
    end

    // Numerator over 960, always within 0..2*delta
    case (s1_sec_nxt)
      gq_pkg::SEC_RED_UP:   xsum = {2'b00, in_green} - {2'b00, in_blue};
      gq_pkg::SEC_RED_DOWN: xsum = {2'b00, s1_d_nxt} + {2'b00, in_green} - {2'b00, in_blue};
      gq_pkg::SEC_GREEN:    xsum = {2'b00, s1_d_nxt} + {2'b00, in_blue} - {2'b00, in_red};
      default:              xsum = {2'b00, s1_d_nxt} + {2'b00, in_red} - {2'b00, in_green};
    endcase
    s1_x_nxt = xsum[gq_pkg::XDIF_W-1:0];

    s1_luma_nxt = gq_pkg::LUMA_W'(in_red)   * 18'd299
                + gq_pkg::LUMA_W'(in_green) * 18'd587
                + gq_pkg::LUMA_W'(in_blue)  * 18'd114;
    s1_mode_nxt = mode;
    s1_gmsb_nxt = in_green[gq_pkg::PIX_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_mode_r <= s1_mode_nxt;
      s1_mx_r   <= s1_mx_nxt;
      s1_d_r    <= s1_d_nxt;
      s1_sec_r  <= s1_sec_nxt;
      s1_x_r    <= s1_x_nxt;
      s1_luma_r <= s1_luma_nxt;
      s1_gmsb_r <= s1_gmsb_nxt;
    end
  end

  // Stage 2: saturation test, dividend 960*x and grey ramp index
  always_comb begin
    d5 = {1'b0, s1_d_r, 2'b00} + {3'b000, s1_d_r};
    gcnt = '0;
    for (int k = 0; k < gq_pkg::RAMP_TOP; k++) begin
      if (s1_luma_r >= gq_pkg::LUMA_THR[k]) begin
        gcnt = gcnt + 4'd1;
      end
    end

    s2_data_nxt.side.mode     = s1_mode_r;
    s2_data_nxt.side.use_grey = (s1_d_r == '0) || (d5 < {3'b000, s1_mx_r});
    s2_data_nxt.side.dark     = !s1_mx_r[gq_pkg::PIX_W-1];
    s2_data_nxt.side.sector   = s1_sec_r;
    s2_data_nxt.side.gidx     = gcnt;
    s2_data_nxt.side.g_msb    = s1_gmsb_r;
    s2_data_nxt.dividend      = {s1_x_r, 10'b0} - {4'b0000, s1_x_r, 6'b0};
    s2_data_nxt.divisor       = s1_d_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      s2_data_r <= s2_data_nxt;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_data  = s2_data_r;

endmodule

>>> hw/rtl/gq_div.sv
module gq_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  gq_pkg::div_in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output gq_pkg::div_out_t out_data
);

  localparam int unsigned NS = gq_pkg::DIV_STAGES;
  localparam int unsigned QW = gq_pkg::QUO_W;
  localparam int unsigned RW = gq_pkg::REM_W;

  // Stage registers, one entry per stage
  logic                      st_valid_r [NS];
  gq_pkg::side_t             st_side_r  [NS];
  logic [RW-1:0]             st_rem_r   [NS];
  logic [QW-1:0]             st_lo_r    [NS];
  logic [QW-1:0]             st_quot_r  [NS];
  logic [gq_pkg::PIX_W-1:0]  st_dvs_r   [NS];

  // Stage inputs
  logic                      src_valid  [NS];
  gq_pkg::side_t             src_side   [NS];
  logic [RW-1:0]             src_rem    [NS];
  logic [QW-1:0]             src_lo     [NS];
  logic [QW-1:0]             src_quot   [NS];
  logic [gq_pkg::PIX_W-1:0]  src_dvs    [NS];
  logic                      rdy        [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [RW-1:0] rem_nxt;
    logic [QW-1:0] lo_nxt;
    logic [QW-1:0] quot_nxt;
    logic [RW:0]   trial;

    // Feed from the port or the previous stage
    if (s == 0) begin : g_head
      // dividend < 2048*divisor, so its top bits start below the divisor
      assign src_valid[s] = in_valid;
      assign src_side[s]  = in_data.side;
      assign src_rem[s]   = in_data.dividend[gq_pkg::DIVD_W-1:QW];
      assign src_lo[s]    = in_data.dividend[QW-1:0];
      assign src_quot[s]  = '0;
      assign src_dvs[s]   = in_data.divisor;
    end else begin : g_link
      assign src_valid[s] = st_valid_r[s-1];
      assign src_side[s]  = st_side_r[s-1];
      assign src_rem[s]   = st_rem_r[s-1];
      assign src_lo[s]    = st_lo_r[s-1];
      assign src_quot[s]  = st_quot_r[s-1];
      assign src_dvs[s]   = st_dvs_r[s-1];
    end

    if (s == NS - 1) begin : g_tail
      assign rdy[s] = !st_valid_r[s] || out_ready;
    end else begin : g_mid
      assign rdy[s] = !st_valid_r[s] || rdy[s+1];
    end

    // Restoring division: shift in one dividend bit, subtract when it fits
    always_comb begin
      rem_nxt  = src_rem[s];
      lo_nxt   = src_lo[s];
      quot_nxt = src_quot[s];
      trial    = '0;
      for (int j = 0; j < gq_pkg::DIV_STEPS; j++) begin
        if (s * gq_pkg::DIV_STEPS + j < QW) begin
          trial  = {rem_nxt, lo_nxt[QW-1]};
          lo_nxt = {lo_nxt[QW-2:0], 1'b0};
          if (trial >= {1'b0, src_dvs[s]}) begin
            rem_nxt  = RW'(trial - {1'b0, src_dvs[s]});
            quot_nxt = {quot_nxt[QW-2:0], 1'b1};
          end else begin
            rem_nxt  = trial[RW-1:0];
            quot_nxt = {quot_nxt[QW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_valid_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        st_valid_r[s] <= src_valid[s];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && src_valid[s]) begin
        st_side_r[s] <= src_side[s];
        st_rem_r[s]  <= rem_nxt;
        st_lo_r[s]   <= lo_nxt;
        st_quot_r[s] <= quot_nxt;
        st_dvs_r[s]  <= src_dvs[s];
      end
    end
  end

  assign in_ready      = rdy[0];
  assign out_valid     = st_valid_r[NS-1];
  assign out_data.side = st_side_r[NS-1];
  assign out_data.quot = st_quot_r[NS-1];

endmodule

>>> hw/rtl/gq_back.sv
module gq_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gq_pkg::div_out_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output gq_pkg::result_t   out_data
);

  logic                          res_valid_r;
  gq_pkg::result_t               res_r, res_nxt;
  gq_pkg::result_t               grey_res, hue_res;
  logic [gq_pkg::HUE_W-1:0]      hue;
  logic [2:0]                    band;
  logic [gq_pkg::GIDX_W-1:0]     gidx;

  assign in_ready = !res_valid_r || out_ready;
  assign gidx     = in_data.side.gidx;

  // Grey ramp lookup
  always_comb begin
    grey_res.glyph = gq_pkg::GLYPH_W'(gidx - 4'd1);
    case (gidx) inside
      4'd0: begin
        grey_res.glyph = gq_pkg::GLYPH_SOLID;
        grey_res.fore  = gq_pkg::COL_BLACK;
        grey_res.back  = gq_pkg::COL_BLACK;
      end
      [4'd1:4'd4]: begin
        grey_res.fore = gq_pkg::COL_DGREY;
        grey_res.back = gq_pkg::COL_BLACK;
      end
      [4'd5:4'd8]: begin
        grey_res.fore = gq_pkg::COL_GREY;
        grey_res.back = gq_pkg::COL_DGREY;
      end
      default: begin
        grey_res.fore = gq_pkg::COL_WHITE;
        grey_res.back = gq_pkg::COL_GREY;
      end
    endcase
  end

  // Hue: sector base plus quotient, then band and glyph
  always_comb begin
    hue           = gq_pkg::sector_base(in_data.side.sector)
                  + gq_pkg::HUE_W'(in_data.quot);
    band          = gq_pkg::hue_band(hue);
    hue_res.glyph = gq_pkg::quot_glyph(in_data.quot);
    hue_res.fore  = gq_pkg::band_fore(band, in_data.side.dark);
    hue_res.back  = gq_pkg::band_back(band, in_data.side.dark);
  end

  // Select by render mode
  always_comb begin
    unique case (in_data.side.mode)
      gq_pkg::MODE_BW: begin
        res_nxt.glyph = gq_pkg::GLYPH_SOLID;
        res_nxt.fore  = in_data.side.g_msb ? gq_pkg::COL_WHITE : gq_pkg::COL_BLACK;
        res_nxt.back  = gq_pkg::COL_BLACK;
      end
      gq_pkg::MODE_GREY: res_nxt = grey_res;
      default:           res_nxt = in_data.side.use_grey ? grey_res : hue_res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (in_ready) begin
      res_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = res_valid_r;
  assign out_data  = res_r;

endmodule

>>> hw/rtl/rgb_to_console_glyph_quantizer_core.sv
// RGB pixel to console glyph and colors.
//
// in_*  : one pixel word per handshake, red/green/blue packed in in_tdata.
// out_* : one result word per pixel, in order: glyph, foreground and
//         background palette index packed in out_tdata.
// cfg_* : writes the render mode (1 black/white, 2 grey ramp, 3 or 0 hue
//         color). Write it only while no pixel is in flight.
//
// Throughput is one pixel per cycle while out_tready is high. A pixel
// passes two front stages (min/max, luma, then the saturation test and
// dividend), four stages of the restoring hue divider at three quotient
// bits each (two in the last), and the output register.
//
// Reset empties every stage and sets the mode to hue color. When the
// receiver holds out_tready low, the output word holds and the stages
// behind it keep filling empty slots; in_tready drops only once every
// stage holds a word.
module rgb_to_console_glyph_quantizer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [1:0] glyph, [5:2] fore_colour, [9:6] back_colour
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);

  logic [gq_pkg::MODE_W-1:0] mode_r;
  logic                      fr_valid, fr_ready;
  gq_pkg::div_in_t           fr_data;
  logic                      dv_valid, dv_ready;
  gq_pkg::div_out_t          dv_data;
  gq_pkg::result_t           res;

  // Mode register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= gq_pkg::MODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  gq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_red    (in_tdata[7:0]),
    .in_green  (in_tdata[15:8]),
    .in_blue   (in_tdata[23:16]),
    .mode      (mode_r),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_data  (fr_data)
  );

  gq_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (fr_data),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_data  (dv_data)
  );

  gq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .in_data   (dv_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res)
  );

  assign out_tdata = {6'b000000, res.back, res.fore, res.glyph};

  // An empty output register means every stage can advance
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output register");

  // Black foreground only comes with a solid glyph on black
  a_black_is_solid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[5:2] == gq_pkg::COL_BLACK)
      |-> (out_tdata[1:0] == gq_pkg::GLYPH_SOLID && out_tdata[9:6] == gq_pkg::COL_BLACK))
    else $error("black foreground without solid glyph on black");

  // Nothing leaves the pipe right after reset
  a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_tvalid)
    else $error("output valid right after reset");

endmodule
